>>> rtl/span_clip_pattern_tiler_core_assert.svh
// Assertion macros shared by the span tiler modules.
// Both macros sample on clk_i; the first one is masked while rst_ni is low.
`ifndef SPAN_CLIP_PATTERN_TILER_CORE_ASSERT_SVH
`define SPAN_CLIP_PATTERN_TILER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SPT_ASSERT(label, prop, msg)
`define SPT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/spt_pkg.sv
package spt_pkg;

  // Geometry
  localparam int SCREEN_SIZE       = 1024;
  localparam int MAX_PATTERN_WIDTH = 256;
  localparam int MIN_PATTERN_WIDTH = 32;
  localparam int MAX_PATTERN_HEIGHT = 256;

  localparam int COORD_W = $clog2(SCREEN_SIZE);   // 10
  localparam int SPAN_W  = 12;                    // signed span coordinates
  localparam int DEST_W  = COORD_W + 1;           // signed viewport offsets
  localparam int PAT_W   = 9;                     // pattern size registers
  localparam int SRC_W   = 8;                     // pattern column / row
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 10;

  // Queue between classifier and emitter
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_CLIP_LEFT      = 4'd0;
  localparam logic [IDX_W-1:0] REG_CLIP_TOP       = 4'd1;
  localparam logic [IDX_W-1:0] REG_CLIP_RIGHT     = 4'd2;
  localparam logic [IDX_W-1:0] REG_CLIP_BOTTOM    = 4'd3;
  localparam logic [IDX_W-1:0] REG_PATTERN_WIDTH  = 4'd4;
  localparam logic [IDX_W-1:0] REG_PATTERN_HEIGHT = 4'd5;
  localparam logic [IDX_W-1:0] REG_VIEWPORT_LEFT  = 4'd6;
  localparam logic [IDX_W-1:0] REG_VIEWPORT_TOP   = 4'd7;

  // Command codes
  localparam logic CMD_SOLID = 1'b0;
  localparam logic CMD_BLIT  = 1'b1;

  // Decoded configuration
  typedef struct packed {
    logic [COORD_W-1:0] clip_left;
    logic [COORD_W-1:0] clip_top;
    logic [COORD_W-1:0] clip_right;
    logic [COORD_W-1:0] clip_bottom;
    logic               pat_on;
    logic [PAT_W-1:0]   w_div;     // clamped tile width
    logic [PAT_W-1:0]   h_div;     // clamped tile height
    logic [COORD_W-1:0] vp_left;
    logic [COORD_W-1:0] vp_top;
  } cfg_t;

  // One classified span
  typedef struct packed {
    logic               solid;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] xe;
    logic [SRC_W-1:0]   left;      // xs mod tile width
    logic [SRC_W-1:0]   row;       // y mod tile height
    logic [DEST_W-1:0]  dy;
  } desc_t;

endpackage

>>> rtl/spt_cfg.sv
module spt_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [spt_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [spt_pkg::DATA_W-1:0]  cfg_data_i,
  output spt_pkg::cfg_t               cfg_o
);

  logic [spt_pkg::COORD_W-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [spt_pkg::COORD_W-1:0] vp_left_q, vp_top_q;
  logic [spt_pkg::PAT_W-1:0]   pat_w_q, pat_h_q;

  assign cfg_ready_o = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_right_q  <= spt_pkg::COORD_W'(spt_pkg::SCREEN_SIZE - 1);
      clip_bottom_q <= spt_pkg::COORD_W'(spt_pkg::SCREEN_SIZE - 1);
      pat_w_q       <= '0;
      pat_h_q       <= spt_pkg::PAT_W'(1);
      vp_left_q     <= '0;
      vp_top_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spt_pkg::REG_CLIP_LEFT:      clip_left_q   <= cfg_data_i[spt_pkg::COORD_W-1:0];
        spt_pkg::REG_CLIP_TOP:       clip_top_q    <= cfg_data_i[spt_pkg::COORD_W-1:0];
        spt_pkg::REG_CLIP_RIGHT:     clip_right_q  <= cfg_data_i[spt_pkg::COORD_W-1:0];
        spt_pkg::REG_CLIP_BOTTOM:    clip_bottom_q <= cfg_data_i[spt_pkg::COORD_W-1:0];
        spt_pkg::REG_PATTERN_WIDTH:  pat_w_q       <= cfg_data_i[spt_pkg::PAT_W-1:0];
        spt_pkg::REG_PATTERN_HEIGHT: pat_h_q       <= cfg_data_i[spt_pkg::PAT_W-1:0];
        spt_pkg::REG_VIEWPORT_LEFT:  vp_left_q     <= cfg_data_i[spt_pkg::COORD_W-1:0];
        spt_pkg::REG_VIEWPORT_TOP:   vp_top_q      <= cfg_data_i[spt_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp tile size into the supported range
  always_comb begin
    cfg_o.clip_left   = clip_left_q;
    cfg_o.clip_top    = clip_top_q;
    cfg_o.clip_right  = clip_right_q;
    cfg_o.clip_bottom = clip_bottom_q;
    cfg_o.vp_left     = vp_left_q;
    cfg_o.vp_top      = vp_top_q;
    cfg_o.pat_on      = (pat_w_q != '0);
    if (pat_w_q < spt_pkg::PAT_W'(spt_pkg::MIN_PATTERN_WIDTH))
      cfg_o.w_div = spt_pkg::PAT_W'(spt_pkg::MIN_PATTERN_WIDTH);
    else if (pat_w_q > spt_pkg::PAT_W'(spt_pkg::MAX_PATTERN_WIDTH))
      cfg_o.w_div = spt_pkg::PAT_W'(spt_pkg::MAX_PATTERN_WIDTH);
    else
      cfg_o.w_div = pat_w_q;
    if (pat_h_q == '0)
      cfg_o.h_div = spt_pkg::PAT_W'(1);
    else if (pat_h_q > spt_pkg::PAT_W'(spt_pkg::MAX_PATTERN_HEIGHT))
      cfg_o.h_div = spt_pkg::PAT_W'(spt_pkg::MAX_PATTERN_HEIGHT);
    else
      cfg_o.h_div = pat_h_q;
  end

endmodule

>>> rtl/spt_front.sv
module spt_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spt_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [spt_pkg::SPAN_W-1:0] span_y_i,
  input  logic signed [spt_pkg::SPAN_W-1:0] span_x_start_i,
  input  logic signed [spt_pkg::SPAN_W-1:0] span_x_end_i,
  output logic                              push_o,
  output spt_pkg::desc_t                    desc_o,
  input  logic                              full_i
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  localparam int CNT_W = $clog2(spt_pkg::COORD_W);
  localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(spt_pkg::COORD_W - 1);

  fstate_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  spt_pkg::desc_t   desc_q, desc_d;

  logic signed [spt_pkg::SPAN_W-1:0] xs_c, xe_c;
  logic row_out, empty, accept;
  logic [CNT_W-1:0] bit_idx;

  // One restoring remainder step
  function automatic logic [spt_pkg::SRC_W-1:0] mod_step(
    input logic [spt_pkg::SRC_W-1:0] rem,
    input logic                      din,
    input logic [spt_pkg::PAT_W-1:0] d
  );
    logic [spt_pkg::PAT_W-1:0] t;
    t = {rem, din};
    if (t >= d) t = t - d;
    return t[spt_pkg::SRC_W-1:0];
  endfunction

  // Clip against the rectangle
  always_comb begin
    row_out = (span_y_i < $signed({2'b00, cfg_i.clip_top})) ||
              (span_y_i > $signed({2'b00, cfg_i.clip_bottom}));
    xs_c = (span_x_start_i < $signed({2'b00, cfg_i.clip_left})) ?
           $signed({2'b00, cfg_i.clip_left}) : span_x_start_i;
    xe_c = (span_x_end_i > $signed({2'b00, cfg_i.clip_right})) ?
           $signed({2'b00, cfg_i.clip_right}) : span_x_end_i;
    empty = row_out || (xe_c < xs_c);
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign bit_idx    = TOP_BIT - cnt_q;
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign desc_o     = desc_q;

  // Classifier sequencer: accept, divide for pattern spans, hand over; empty spans are dropped
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    desc_d  = desc_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept && !empty) begin
          desc_d.solid = !cfg_i.pat_on;
          desc_d.y     = span_y_i[spt_pkg::COORD_W-1:0];
          desc_d.xs    = xs_c[spt_pkg::COORD_W-1:0];
          desc_d.xe    = xe_c[spt_pkg::COORD_W-1:0];
          desc_d.left  = '0;
          desc_d.row   = '0;
          desc_d.dy    = {1'b0, span_y_i[spt_pkg::COORD_W-1:0]} - {1'b0, cfg_i.vp_top};
          cnt_d        = '0;
          state_d      = cfg_i.pat_on ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        desc_d.left = mod_step(desc_q.left, desc_q.xs[bit_idx], cfg_i.w_div);
        desc_d.row  = mod_step(desc_q.row, desc_q.y[bit_idx], cfg_i.h_div);
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == TOP_BIT) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

`include "span_clip_pattern_tiler_core_assert.svh"

  `SPT_ASSERT(a_div_ends, (state_q == F_DIV && cnt_q == TOP_BIT) |=> (state_q == F_PUSH), "divide did not finish")
  `SPT_ASSERT(a_push_full, push_o |-> (state_q == F_PUSH && !full_i), "push into full queue")

endmodule

>>> rtl/spt_fifo.sv
module spt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spt_pkg::desc_t desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output spt_pkg::desc_t desc_o
);

  spt_pkg::desc_t mem_q [spt_pkg::QDEPTH];
  logic [spt_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [spt_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (spt_pkg::QPTR_W+1)'(spt_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign desc_o  = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == spt_pkg::QPTR_W'(spt_pkg::QDEPTH - 1)) ? '0 :
                          wr_q + spt_pkg::QPTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == spt_pkg::QPTR_W'(spt_pkg::QDEPTH - 1)) ? '0 :
                          rd_q + spt_pkg::QPTR_W'(1);
      cnt_q <= cnt_q + (spt_pkg::QPTR_W+1)'(push_i) - (spt_pkg::QPTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= desc_i;
  end

`include "span_clip_pattern_tiler_core_assert.svh"

  `SPT_ASSERT(a_no_overflow, push_i |-> !full_o, "queue overflow")
  `SPT_ASSERT(a_no_underflow, pop_i |-> valid_o, "queue underflow")

endmodule

>>> rtl/spt_back.sv
module spt_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  spt_pkg::cfg_t                      cfg_i,
  input  logic                               q_valid_i,
  output logic                               pop_o,
  input  spt_pkg::desc_t                     desc_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               command_o,
  output logic [spt_pkg::COORD_W-1:0]        line_y_o,
  output logic [spt_pkg::COORD_W-1:0]        line_x_start_o,
  output logic [spt_pkg::COORD_W-1:0]        line_x_end_o,
  output logic [spt_pkg::SRC_W-1:0]          src_left_o,
  output logic [spt_pkg::SRC_W-1:0]          src_right_o,
  output logic [spt_pkg::SRC_W-1:0]          src_row_o,
  output logic signed [spt_pkg::DEST_W-1:0]  dest_x_o,
  output logic signed [spt_pkg::DEST_W-1:0]  dest_y_o,
  output logic                               last_o
);

  logic                        busy_q, busy_d;
  spt_pkg::desc_t              cur_q;
  logic [spt_pkg::COORD_W-1:0] x_q, x_d;
  logic [spt_pkg::SRC_W-1:0]   left_q, left_d;
  logic                        ov_q;

  logic                        slot_free, emit, piece_last;
  logic [spt_pkg::SRC_W-1:0]   wm1, right;
  logic [spt_pkg::DEST_W-1:0]  reach;

  assign slot_free = !ov_q || out_ready_i;
  assign emit      = busy_q && slot_free;
  assign pop_o     = !busy_q && q_valid_i;
  assign wm1       = spt_pkg::SRC_W'(cfg_i.w_div - spt_pkg::PAT_W'(1));

  // Current piece: runs to the tile edge or to the span end
  always_comb begin
    reach      = spt_pkg::DEST_W'(left_q) + spt_pkg::DEST_W'(cur_q.xe - x_q);
    piece_last = cur_q.solid || (reach <= spt_pkg::DEST_W'(wm1));
    right      = piece_last ? reach[spt_pkg::SRC_W-1:0] : wm1;
    x_d        = x_q + spt_pkg::COORD_W'(wm1 - left_q) + spt_pkg::COORD_W'(1);
    left_d     = '0;
    busy_d     = busy_q;
    if (pop_o) busy_d = 1'b1;
    else if (emit && piece_last) busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (slot_free) ov_q <= emit;
    end
  end

  // Span walker
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= desc_i;
      x_q    <= desc_i.xs;
      left_q <= desc_i.left;
    end else if (emit) begin
      x_q    <= x_d;
      left_q <= left_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      last_o <= piece_last;
      if (cur_q.solid) begin
        command_o      <= spt_pkg::CMD_SOLID;
        line_y_o       <= cur_q.y;
        line_x_start_o <= cur_q.xs;
        line_x_end_o   <= cur_q.xe;
        src_left_o     <= '0;
        src_right_o    <= '0;
        src_row_o      <= '0;
        dest_x_o       <= '0;
        dest_y_o       <= '0;
      end else begin
        command_o      <= spt_pkg::CMD_BLIT;
        line_y_o       <= '0;
        line_x_start_o <= '0;
        line_x_end_o   <= '0;
        src_left_o     <= left_q;
        src_right_o    <= right;
        src_row_o      <= cur_q.row;
        dest_x_o       <= {1'b0, x_q} - {1'b0, cfg_i.vp_left};
        dest_y_o       <= cur_q.dy;
      end
    end
  end

  assign out_valid_o = ov_q;

`include "span_clip_pattern_tiler_core_assert.svh"

  `SPT_ASSERT(a_last_frees, (emit && piece_last) |=> !busy_q, "walker busy after last piece")
  `SPT_ASSERT(a_pop_idle, pop_o |=> busy_q, "walker not loaded after pop")

endmodule

>>> rtl/span_clip_pattern_tiler_core.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  span_y_i, span_x_start_i, span_x_end_i
// out      output     out_valid_o/out_ready_i command_o .. last_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The classifier drops a clipped-away span on accept and hands a solid span
// straight over; a pattern span goes through accept, 10 remainder steps of xs mod
// width and y mod height, and hand-over. The emitter loads a span from the queue,
// then gives one command per cycle while the output is not stalled.
// Reset clears control state only; no clearing pass. A two-entry span queue
// between classifier and emitter lets an output stall hold the emitter alone.
module span_clip_pattern_tiler_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [spt_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [spt_pkg::DATA_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [spt_pkg::SPAN_W-1:0]  span_y_i,
  input  logic signed [spt_pkg::SPAN_W-1:0]  span_x_start_i,
  input  logic signed [spt_pkg::SPAN_W-1:0]  span_x_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               command_o,
  output logic [spt_pkg::COORD_W-1:0]        line_y_o,
  output logic [spt_pkg::COORD_W-1:0]        line_x_start_o,
  output logic [spt_pkg::COORD_W-1:0]        line_x_end_o,
  output logic [spt_pkg::SRC_W-1:0]          src_left_o,
  output logic [spt_pkg::SRC_W-1:0]          src_right_o,
  output logic [spt_pkg::SRC_W-1:0]          src_row_o,
  output logic signed [spt_pkg::DEST_W-1:0]  dest_x_o,
  output logic signed [spt_pkg::DEST_W-1:0]  dest_y_o,
  output logic                               last_o
);

  spt_pkg::cfg_t  cfg;
  spt_pkg::desc_t push_desc, pop_desc;
  logic           push, full, pop, q_valid;

  spt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .span_y_i       (span_y_i),
    .span_x_start_i (span_x_start_i),
    .span_x_end_i   (span_x_end_i),
    .push_o         (push),
    .desc_o         (push_desc),
    .full_i         (full)
  );

  spt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (pop_desc)
  );

  spt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .pop_o          (pop),
    .desc_i         (pop_desc),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_o      (command_o),
    .line_y_o       (line_y_o),
    .line_x_start_o (line_x_start_o),
    .line_x_end_o   (line_x_end_o),
    .src_left_o     (src_left_o),
    .src_right_o    (src_right_o),
    .src_row_o      (src_row_o),
    .dest_x_o       (dest_x_o),
    .dest_y_o       (dest_y_o),
    .last_o         (last_o)
  );

endmodule

>>> tb/tb_top.sv
module tb_top;
  import spt_pkg::*;

  // Register indexes past the end of the map; writes to them must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  localparam int DRAIN_CYCLES = 50;

  // One drawing command as it leaves the block
  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] line_y;
    logic [COORD_W-1:0] line_xs;
    logic [COORD_W-1:0] line_xe;
    logic [SRC_W-1:0]   src_left;
    logic [SRC_W-1:0]   src_right;
    logic [SRC_W-1:0]   src_row;
    logic [DEST_W-1:0]  dest_x;
    logic [DEST_W-1:0]  dest_y;
    logic               last;
  } draw_cmd_t;

  // One fill span waiting to be sent
  typedef struct packed {
    logic [SPAN_W-1:0] y;
    logic [SPAN_W-1:0] xs;
    logic [SPAN_W-1:0] xe;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [SPAN_W-1:0] span_y = '0;
  logic [SPAN_W-1:0] span_xs = '0;
  logic [SPAN_W-1:0] span_xe = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              command;
  logic [COORD_W-1:0] line_y, line_x_start, line_x_end;
  logic [SRC_W-1:0]  src_left, src_right, src_row;
  logic [DEST_W-1:0] dest_x, dest_y;
  logic              last_flag;

  // Shadow copy of the register file
  logic [COORD_W-1:0] cfg_clip_left   = '0;
  logic [COORD_W-1:0] cfg_clip_top    = '0;
  logic [COORD_W-1:0] cfg_clip_right  = COORD_W'(SCREEN_SIZE - 1);
  logic [COORD_W-1:0] cfg_clip_bottom = COORD_W'(SCREEN_SIZE - 1);
  logic [PAT_W-1:0]   cfg_pat_width   = '0;
  logic [PAT_W-1:0]   cfg_pat_height  = PAT_W'(1);
  logic [COORD_W-1:0] cfg_vp_left     = '0;
  logic [COORD_W-1:0] cfg_vp_top      = '0;

  span_t       pending_spans[$];
  draw_cmd_t   expected_cmds[$];
  int          spans_queued = 0;
  int          spans_taken = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  span_clip_pattern_tiler_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .span_y_i       (span_y),
    .span_x_start_i (span_xs),
    .span_x_end_i   (span_xe),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .command_o      (command),
    .line_y_o       (line_y),
    .line_x_start_o (line_x_start),
    .line_x_end_o   (line_x_end),
    .src_left_o     (src_left),
    .src_right_o    (src_right),
    .src_row_o      (src_row),
    .dest_x_o       (dest_x),
    .dest_y_o       (dest_y),
    .last_o         (last_flag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register write into the shadow copy; unknown indexes are dropped
  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    case (idx)
      REG_CLIP_LEFT:      cfg_clip_left   = data[COORD_W-1:0];
      REG_CLIP_TOP:       cfg_clip_top    = data[COORD_W-1:0];
      REG_CLIP_RIGHT:     cfg_clip_right  = data[COORD_W-1:0];
      REG_CLIP_BOTTOM:    cfg_clip_bottom = data[COORD_W-1:0];
      REG_PATTERN_WIDTH:  cfg_pat_width   = data[PAT_W-1:0];
      REG_PATTERN_HEIGHT: cfg_pat_height  = data[PAT_W-1:0];
      REG_VIEWPORT_LEFT:  cfg_vp_left     = data[COORD_W-1:0];
      REG_VIEWPORT_TOP:   cfg_vp_top      = data[COORD_W-1:0];
      default: ;
    endcase
  endfunction

  // Clip one span and cut it into tile pieces, queueing the commands it yields
  function automatic void tile_span(logic [SPAN_W-1:0] y_in, logic [SPAN_W-1:0] xs_in,
                                    logic [SPAN_W-1:0] xe_in);
    int y, xs, xe, w, h, x, left, right;
    draw_cmd_t c;
    y  = $signed(y_in);
    xs = $signed(xs_in);
    xe = $signed(xe_in);
    if (y < int'(cfg_clip_top) || y > int'(cfg_clip_bottom)) return;
    if (xs < int'(cfg_clip_left)) xs = int'(cfg_clip_left);
    if (xe > int'(cfg_clip_right)) xe = int'(cfg_clip_right);
    if (xe < xs) return;
    c = '0;
    if (cfg_pat_width == '0) begin
      c.command = CMD_SOLID;
      c.line_y  = COORD_W'(y);
      c.line_xs = COORD_W'(xs);
      c.line_xe = COORD_W'(xe);
      c.last    = 1'b1;
      expected_cmds.push_back(c);
      return;
    end
    // out-of-range tile sizes are clamped
    w = int'(cfg_pat_width);
    if (w < MIN_PATTERN_WIDTH) w = MIN_PATTERN_WIDTH;
    if (w > MAX_PATTERN_WIDTH) w = MAX_PATTERN_WIDTH;
    h = int'(cfg_pat_height);
    if (h < 1) h = 1;
    if (h > MAX_PATTERN_HEIGHT) h = MAX_PATTERN_HEIGHT;
    x = xs;
    while (x <= xe) begin
      left  = x % w;
      right = left + (xe - x);
      if (right > w - 1) right = w - 1;
      c = '0;
      c.command   = CMD_BLIT;
      c.src_left  = SRC_W'(left);
      c.src_right = SRC_W'(right);
      c.src_row   = SRC_W'(y % h);
      c.dest_x    = DEST_W'(x - int'(cfg_vp_left));
      c.dest_y    = DEST_W'(y - int'(cfg_vp_top));
      c.last      = (x + right - left + 1 > xe);
      expected_cmds.push_back(c);
      x += right - left + 1;
    end
  endfunction

  function automatic string fmt_cmd(draw_cmd_t c);
    return $sformatf("cmd=%0d line y=%0d x=%0d..%0d src=%0d..%0d row=%0d dest=(%0d,%0d) last=%0d",
                     c.command, c.line_y, c.line_xs, c.line_xe, c.src_left, c.src_right,
                     c.src_row, $signed(c.dest_x), $signed(c.dest_y), c.last);
  endfunction

  // Span driver: predicts on each accepted transaction, then offers the next span
  always @(posedge clk) begin : span_driver
    span_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tile_span(span_y, span_xs, span_xe);
        spans_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_spans.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_spans.pop_front();
          in_valid <= 1'b1;
          span_y   <= nxt.y;
          span_xs  <= nxt.xs;
          span_xe  <= nxt.xe;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Command monitor and scoreboard
  always @(posedge clk) begin : cmd_monitor
    draw_cmd_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {command, line_y, line_x_start, line_x_end, src_left, src_right, src_row,
             dest_x, dest_y, last_flag};
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("command with nothing expected: %s", fmt_cmd(got));
      end else begin
        want = expected_cmds.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("command mismatch, expected %s", fmt_cmd(want));
            $display("                  actual   %s", fmt_cmd(got));
          end
        end
      end
    end
  end

  // One register write transaction; called and returns on a rising edge
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [DATA_W-1:0] cl, ct, cr, cb, pw, ph, vl, vt);
    write_reg(REG_CLIP_LEFT, cl);
    write_reg(REG_CLIP_TOP, ct);
    write_reg(REG_CLIP_RIGHT, cr);
    write_reg(REG_CLIP_BOTTOM, cb);
    write_reg(REG_PATTERN_WIDTH, pw);
    write_reg(REG_PATTERN_HEIGHT, ph);
    write_reg(REG_VIEWPORT_LEFT, vl);
    write_reg(REG_VIEWPORT_TOP, vt);
  endtask

  task automatic rand_config();
    logic [DATA_W-1:0] cl, ct, cr, cb, pw, ph, vl, vt;
    cl = DATA_W'($urandom_range(600));
    cr = DATA_W'($urandom_range(SCREEN_SIZE - 1, cl));
    ct = DATA_W'($urandom_range(900));
    cb = DATA_W'($urandom_range(SCREEN_SIZE - 1, ct));
    if ($urandom_range(4) == 0) begin
      cl = '0;
      ct = '0;
      cr = DATA_W'(SCREEN_SIZE - 1);
      cb = DATA_W'(SCREEN_SIZE - 1);
    end
    case ($urandom_range(4))
      0:       pw = '0;
      1:       pw = DATA_W'(MIN_PATTERN_WIDTH);
      2:       pw = DATA_W'(MAX_PATTERN_WIDTH);
      3:       pw = DATA_W'($urandom_range(MAX_PATTERN_WIDTH, MIN_PATTERN_WIDTH));
      default: pw = DATA_W'($urandom_range(511));
    endcase
    if ($urandom_range(3) == 0) ph = DATA_W'($urandom_range(511));
    else ph = DATA_W'($urandom_range(MAX_PATTERN_HEIGHT, 1));
    // bit 9 is unused by the 9-bit registers
    pw[DATA_W-1] = 1'($urandom_range(1));
    ph[DATA_W-1] = 1'($urandom_range(1));
    vl = DATA_W'($urandom_range(SCREEN_SIZE - 1));
    vt = DATA_W'($urandom_range(SCREEN_SIZE - 1));
    write_all(cl, ct, cr, cb, pw, ph, vl, vt);
  endtask

  task automatic queue_span(input int y, input int xs, input int xe);
    span_t s;
    s.y  = SPAN_W'(y);
    s.xs = SPAN_W'(xs);
    s.xe = SPAN_W'(xe);
    pending_spans.push_back(s);
    spans_queued++;
  endtask

  // Mostly spans inside the clip rows near the clip columns, some pure noise
  task automatic queue_random_span();
    int y, xs, xe;
    if ($urandom_range(99) < 80) begin
      y  = $urandom_range(cfg_clip_bottom, cfg_clip_top);
      xs = $urandom_range(cfg_clip_right, cfg_clip_left);
      if ($urandom_range(3) == 0) xs = xs - int'($urandom_range(64));
      xe = xs + int'($urandom_range(($urandom_range(3) == 0) ? 1100 : 200));
      if (xe > 2047) xe = 2047;
      queue_span(y, xs, xe);
    end else begin
      queue_span($urandom, $urandom, $urandom);
    end
  endtask

  task automatic set_idling(input int m);
    case (m % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  // Wait until every span is taken and every command seen, then let the pipe empty
  task automatic drain();
    while (spans_taken != spans_queued || expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int ph;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: solid fill, full-screen clip
    set_idling(0);
    queue_span(0, 0, 0);
    queue_span(1023, 1023, 1023);
    queue_span(-2048, -2048, 2047);
    queue_span(2047, 0, 10);
    queue_span(512, -2048, 2047);
    queue_span(300, 700, 200);
    queue_span(-1, 5, 5);
    drain();

    // Narrow tile, zero height, viewport at far corner
    write_all(10'd100, 10'd50, 10'd900, 10'd700, 10'd32, 10'd0, 10'd1023, 10'd1023);
    set_idling(1);
    queue_span(50, -100, 2047);
    queue_span(700, 131, 131);
    queue_span(49, 200, 300);
    queue_span(701, 200, 300);
    queue_span(400, 901, 1000);
    queue_span(400, 0, 99);
    queue_span(400, 127, 128);
    drain();

    // Inverted clip rectangle, plus writes to indexes beyond the map
    write_all(10'd600, 10'd500, 10'd500, 10'd400, 10'd256, 10'd256, 10'd0, 10'd0);
    write_reg(REG_UNUSED_LO, 10'h3FF);
    write_reg(REG_UNUSED_HI, 10'h155);
    set_idling(2);
    queue_span(450, 550, 550);
    queue_span(450, 0, 1023);
    drain();

    // Oversized width and height clamp to the maximum
    write_all(10'd0, 10'd0, 10'd1023, 10'd1023, 10'h3FF, 10'h3FF, 10'd0, 10'd0);
    set_idling(3);
    queue_span(1023, -2048, 2047);
    queue_span(255, 255, 256);
    queue_span(256, 0, 0);
    drain();

    // Undersized width clamps to the minimum: long spans give the most pieces
    write_all(10'd0, 10'd0, 10'd1023, 10'd1023, 10'd5, 10'd300, 10'd512, 10'd0);
    set_idling(2);
    queue_span(600, 31, 1023);
    queue_span(3, 0, 1023);
    drain();

    // Random settings and spans
    for (ph = 0; ph < 8; ph++) begin
      rand_config();
      set_idling(ph);
      repeat (17) queue_random_span();
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
